// ----- rtl/core/lcfl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the LED cube frame latch.
// No dependencies; used by every module of the block.
package lcfl_pkg;

    localparam int CUBE_SIDE  = 8;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 3;
    localparam int ROW_CNT_W  = 6;
    localparam int CMD_DEPTH  = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_LATCH = 1'b1
    } req_t;

    typedef struct packed {
        logic [CUBE_SIDE-1:0][BYTE_W-1:0] lines;
        logic [BYTE_W-1:0]                mask;
    } frame_t;

    typedef struct packed {
        logic   push;
        frame_t frame;
    } cmd_push_t;

    typedef struct packed {
        logic   full;
        logic   empty;
    } cmd_status_t;

endpackage

// ----- rtl/core/lcfl_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input beats, keeps the byte queue and latch level,
// and turns a rising latch into a frame command. Depends on lcfl_pkg.
module lcfl_front #(
    parameter int QUEUE_DEPTH = 9
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lcfl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  lcfl_pkg::cmd_status_t          cmd_status,
    output lcfl_pkg::cmd_push_t            cmd_push
);
    import lcfl_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [BYTE_W-1:0] store_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              latch_high_reg, latch_high_next;
    logic              accept;
    logic              is_latch;
    logic              level;
    logic              rise;
    frame_t            frame;

    assign s_tready = !cmd_status.full;
    assign accept   = s_tvalid && s_tready;
    assign is_latch = (req_t'(s_tuser) == REQ_LATCH);
    assign level    = s_tdata[BYTE_W];
    assign rise     = accept && is_latch && !latch_high_reg && level;

    always_comb begin
        frame.mask = store_mem[0];
        for (int y = 0; y < CUBE_SIDE; y++) begin
            if (CNT_W'(y + 1) < count_reg) begin
                frame.lines[y] = store_mem[y + 1];
            end else begin
                frame.lines[y] = '0;
            end
        end
    end

    assign cmd_push.push  = rise && (count_reg != '0);
    assign cmd_push.frame = frame;

    always_comb begin
        count_next      = count_reg;
        latch_high_next = latch_high_reg;
        if (accept) begin
            if (!is_latch) begin
                if (count_reg < CNT_W'(QUEUE_DEPTH)) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end else if (latch_high_reg && !level) begin
                latch_high_next = 1'b0;
            end else if (rise) begin
                latch_high_next = 1'b1;
                count_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            latch_high_reg <= 1'b1;
        end else begin
            count_reg      <= count_next;
            latch_high_reg <= latch_high_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !is_latch && (count_reg < CNT_W'(QUEUE_DEPTH))) begin
            store_mem[count_reg[PTR_W-1:0]] <= s_tdata[BYTE_W-1:0];
        end
    end

endmodule

// ----- rtl/core/lcfl_cmd_fifo.sv -----
`timescale 1ns / 1ps
// Short frame command queue between front and back end.
// Depends on lcfl_pkg.
module lcfl_cmd_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lcfl_pkg::cmd_push_t   cmd_push,
    input  logic                  pop,
    output lcfl_pkg::frame_t      head,
    output lcfl_pkg::cmd_status_t cmd_status
);
    import lcfl_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    frame_t           cmd_mem [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign cmd_status.full  = (count_reg == CNT_W'(CMD_DEPTH));
    assign cmd_status.empty = (count_reg == '0);
    assign do_push = cmd_push.push && !cmd_status.full;
    assign do_pop  = pop && !cmd_status.empty;
    assign head    = cmd_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            cmd_mem[wr_ptr_reg] <= cmd_push.frame;
        end
    end

endmodule

// ----- rtl/core/lcfl_back.sv -----
`timescale 1ns / 1ps
// Back end: takes one frame command and emits its 64 rows through an
// output register. Depends on lcfl_pkg.
module lcfl_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lcfl_pkg::frame_t               head,
    input  lcfl_pkg::cmd_status_t          cmd_status,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lcfl_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import lcfl_pkg::*;

    localparam int PAD_W = M_TDATA_W - 2 * IDX_W - BYTE_W;

    frame_t               frame_reg, frame_next;
    logic                 busy_reg, busy_next;
    logic [ROW_CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic                 valid_reg, valid_next;
    logic [IDX_W-1:0]     plane_reg, plane_next;
    logic [IDX_W-1:0]     line_reg, line_next;
    logic [BYTE_W-1:0]    led_reg, led_next;
    logic                 last_reg, last_next;
    logic                 advance;
    logic                 last_cnt;
    logic [IDX_W-1:0]     z;
    logic [IDX_W-1:0]     y;

    assign advance  = !valid_reg || m_tready;
    assign pop      = !busy_reg && !cmd_status.empty;
    assign z        = row_cnt_reg[ROW_CNT_W-1:IDX_W];
    assign y        = row_cnt_reg[IDX_W-1:0];
    assign last_cnt = (row_cnt_reg == '1);

    always_comb begin
        frame_next   = frame_reg;
        busy_next    = busy_reg;
        row_cnt_next = row_cnt_reg;
        valid_next   = valid_reg;
        plane_next   = plane_reg;
        line_next    = line_reg;
        led_next     = led_reg;
        last_next    = last_reg;
        if (pop) begin
            frame_next   = head;
            busy_next    = 1'b1;
            row_cnt_next = '0;
        end
        if (advance) begin
            valid_next = busy_reg;
            if (busy_reg) begin
                plane_next   = z;
                line_next    = y;
                led_next     = frame_reg.mask[z] ? frame_reg.lines[y] : '0;
                last_next    = last_cnt;
                row_cnt_next = row_cnt_reg + ROW_CNT_W'(1);
                busy_next    = !last_cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            row_cnt_reg <= '0;
        end else begin
            busy_reg    <= busy_next;
            valid_reg   <= valid_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
        plane_reg <= plane_next;
        line_reg  <= line_next;
        led_reg   <= led_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, led_reg, line_reg, plane_reg};
    assign m_tlast  = last_reg;

endmodule

// ----- rtl/core/led_cube_frame_latch_top.sv -----
`timescale 1ns / 1ps
// LED cube frame latch for an 8x8x8 cube, top level.
// Depends on lcfl_pkg, lcfl_front, lcfl_cmd_fifo and lcfl_back.
//
// Input channel s_*: each beat is a byte write (tuser low) or a latch
// level (tuser high). Byte writes fill a queue of QUEUE_DEPTH bytes; a write
// to a full queue is dropped. A low-to-high latch level with bytes queued
// takes the whole queue as one frame: mask byte first, then up to eight line
// bytes, absent lines reading as zero.
// Output channel m_*: 64 row beats per frame, plane 0..7, line 0..7 within
// each plane; tlast marks the final row.
// Throughput: one input beat per cycle while s_tready is high; one row per cycle at
// the output while m_tready is high, with a pause between frames to load the next one.
// With the back end idle, a latched frame passes the command queue and
// the frame register, then its first row leaves the output register.
// Up to two frames wait in the command queue; with it full, s_tready drops
// until the back end takes the next frame. An output stall holds the current
// row and the row counter.
// Reset: byte queue empty, latch level recorded high, no frames pending.
module led_cube_frame_latch_top #(
    parameter int QUEUE_DEPTH = 9
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lcfl_pkg::S_TDATA_W-1:0] s_tdata,  // data_byte, latch_level, pad
    input  logic                           s_tuser,  // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lcfl_pkg::M_TDATA_W-1:0] m_tdata,  // plane_index, line_index, led_row, pad
    output logic                           m_tlast   // last_row
);
    import lcfl_pkg::*;

    cmd_push_t   cmd_push;
    cmd_status_t cmd_status;
    frame_t      head;
    logic        pop;

    lcfl_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_status(cmd_status),
        .cmd_push  (cmd_push)
    );

    lcfl_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_push  (cmd_push),
        .pop       (pop),
        .head      (head),
        .cmd_status(cmd_status)
    );

    lcfl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .cmd_status(cmd_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
